FILE: design/wsd_pkg.sv
// Package for the work-stealing deque: sizes, command and status codes,
// and the control/status structs shared by controller and datapath. No dependencies.
`default_nettype none
package wsd_pkg;

  localparam int LOG_DEPTH = 10;
  localparam int ELT_WIDTH = 32;
  localparam int PTR_W     = LOG_DEPTH + 1;
  localparam int CAP_W     = 4;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_STEAL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(LOG_DEPTH);

  typedef struct packed {
    logic take_req;   // latch the incoming request
    logic exec;       // apply the request to store and pointers
    logic load_out;   // move the result into the output register
  } wsd_ctrl_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } wsd_stat_t;

endpackage
`default_nettype wire

FILE: design/wsd_ctrl.sv
// Controller for the work-stealing deque: sequences accept, execute and
// result load for one request at a time. Depends on wsd_pkg.
`default_nettype none
module wsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wsd_pkg::wsd_stat_t stat,
  output wsd_pkg::wsd_ctrl_t     ctrl
);
  import wsd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    ctrl.take_req = 1'b0;
    ctrl.exec     = 1'b0;
    ctrl.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.take_req = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

FILE: design/wsd_dp.sv
// Datapath for the work-stealing deque: slot memory, top/bottom pointers,
// capacity register and output register. Depends on wsd_pkg.
`default_nettype none
module wsd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wsd_pkg::wsd_ctrl_t            ctrl,
  output wsd_pkg::wsd_stat_t                 stat,
  input  wire logic [1:0]                    in_command,
  input  wire logic [wsd_pkg::ELT_WIDTH-1:0] in_push_value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wsd_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsd_pkg::ELT_WIDTH-1:0]      out_value,
  output logic [1:0]                         out_status,
  output logic [wsd_pkg::PTR_W-1:0]          out_count
);
  import wsd_pkg::*;

  logic [ELT_WIDTH-1:0] mem [2**LOG_DEPTH];

  logic [1:0]           cmd_r;
  logic [ELT_WIDTH-1:0] val_r;
  logic [PTR_W-1:0]     top_r, top_nxt;
  logic [PTR_W-1:0]     bot_r, bot_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic [ELT_WIDTH-1:0] rd_data_r;
  logic [1:0]           res_status_r, res_status_nxt;
  logic                 res_rd_r, res_rd_nxt;
  logic                 out_valid_r;
  logic [ELT_WIDTH-1:0] out_value_r;
  logic [1:0]           out_status_r;
  logic [PTR_W-1:0]     out_count_r;

  logic [PTR_W-1:0]     held;
  logic [PTR_W-1:0]     cap_n;
  logic [PTR_W-1:0]     last;
  logic                 do_wr;
  logic                 do_rd;
  logic [LOG_DEPTH-1:0] rd_addr;
  logic [CAP_W-1:0]     cap_clamped;

  assign held  = bot_r - top_r;
  assign cap_n = PTR_W'(1) << cap_r;
  assign last  = bot_r - PTR_W'(1);

  always_comb begin
    top_nxt        = top_r;
    bot_nxt        = bot_r;
    res_status_nxt = ST_OK;
    res_rd_nxt     = 1'b0;
    do_wr          = 1'b0;
    do_rd          = 1'b0;
    rd_addr        = top_r[LOG_DEPTH-1:0];
    unique case (cmd_r)
      CMD_PUSH: begin
        if (held >= cap_n) begin
          res_status_nxt = ST_FULL;
        end else begin
          do_wr   = 1'b1;
          bot_nxt = bot_r + PTR_W'(1);
        end
      end
      CMD_POP: begin
        if (held == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          do_rd      = 1'b1;
          res_rd_nxt = 1'b1;
          rd_addr    = last[LOG_DEPTH-1:0];
          // last element: top moves, bottom stays
          if (held == PTR_W'(1)) top_nxt = top_r + PTR_W'(1);
          else                   bot_nxt = last;
        end
      end
      CMD_STEAL: begin
        if (held == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          do_rd      = 1'b1;
          res_rd_nxt = 1'b1;
          top_nxt    = top_r + PTR_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cap_clamped = cfg_wr_data;
    if (cfg_wr_data < CAP_W'(1))              cap_clamped = CAP_W'(1);
    else if (cfg_wr_data > CAP_W'(LOG_DEPTH)) cap_clamped = CAP_W'(LOG_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && do_wr) mem[bot_r[LOG_DEPTH-1:0]] <= val_r;
    if (ctrl.exec && do_rd) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_req) begin
      cmd_r <= in_command;
      val_r <= in_push_value;
    end
    if (ctrl.exec) begin
      res_status_r <= res_status_nxt;
      res_rd_r     <= res_rd_nxt;
    end
    if (ctrl.load_out) begin
      out_value_r  <= res_rd_r ? rd_data_r : '0;
      out_status_r <= res_status_r;
      out_count_r  <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      bot_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        top_r <= top_nxt;
        bot_r <= bot_nxt;
      end
      if (cfg_wr_en) cap_r <= cap_clamped;
      if (ctrl.load_out)   out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;

endmodule
`default_nettype wire

FILE: design/work_stealing_deque_top.sv
// Work-stealing deque top level: controller plus datapath.
// A request passes through accept, execute (with one slot memory access) and
// result load; the load waits while the output register is held by out_stall.
// A new request is taken only after the last result is loaded (in_stall high
// while busy). Reset (synchronous, rst_n low) clears pointers, sets capacity_log2 to 10;
// slot contents are not cleared. Depends on wsd_pkg, wsd_ctrl, wsd_dp.
`default_nettype none
module work_stealing_deque_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_command,
  input  wire logic [wsd_pkg::ELT_WIDTH-1:0] in_push_value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wsd_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsd_pkg::ELT_WIDTH-1:0]      out_value,
  output logic [1:0]                         out_status,
  output logic [wsd_pkg::PTR_W-1:0]          out_count
);
  import wsd_pkg::*;

  wsd_ctrl_t ctrl;
  wsd_stat_t stat;

  wsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  wsd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_command    (in_command),
    .in_push_value (in_push_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_count     (out_count)
  );

endmodule
`default_nettype wire
